// ----- rtl/cvt_pkg.sv -----
// Shared types, constants and saturation helpers for the constant-velocity tracker.
// Used by cvt_div, cvt_ctrl, cvt_datapath and the top level.
`default_nettype none

package cvt_pkg;

  // Fixed-point layout
  localparam int COV_FRAC   = 24;
  localparam int NUM_AXES   = 3;
  localparam int AXIS_W     = 2;
  localparam int MUL_W      = 34;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int PSH_W      = PROD_W - COV_FRAC;
  localparam int DIV_STEPS  = 64;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

  // Configuration port
  localparam int CFG_DATA_W = 31;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_PERIOD     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LOST         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MEASURE_NOISE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_VARIANCE = 3'd4;

  localparam logic [24:0] RST_FRAME_PERIOD     = 25'd167772;
  localparam logic [7:0]  RST_MAX_LOST         = 8'd10;
  localparam logic [30:0] RST_PROCESS_NOISE    = 31'd167772;
  localparam logic [30:0] RST_MEASURE_NOISE    = 31'd41943;
  localparam logic [30:0] RST_INITIAL_VARIANCE = 31'd16777216;

  localparam logic [7:0] LOST_MAX = 8'd255;

  // Datapath operations issued by the controller
  localparam int OP_W = 5;
  localparam logic [OP_W-1:0] OP_NOP          = 5'd0;
  localparam logic [OP_W-1:0] OP_SEED         = 5'd1;
  localparam logic [OP_W-1:0] OP_LOST         = 5'd2;
  localparam logic [OP_W-1:0] OP_PRED_DTC     = 5'd3;
  localparam logic [OP_W-1:0] OP_PRED_DTB     = 5'd4;
  localparam logic [OP_W-1:0] OP_PRED_DTDTC   = 5'd5;
  localparam logic [OP_W-1:0] OP_PRED_COV     = 5'd6;
  localparam logic [OP_W-1:0] OP_AX_MUL_VDT   = 5'd7;
  localparam logic [OP_W-1:0] OP_AX_INNOV     = 5'd8;
  localparam logic [OP_W-1:0] OP_AX_MUL_APE   = 5'd9;
  localparam logic [OP_W-1:0] OP_AX_POS       = 5'd10;
  localparam logic [OP_W-1:0] OP_AX_VEL       = 5'd11;
  localparam logic [OP_W-1:0] OP_CV_MUL_APR   = 5'd12;
  localparam logic [OP_W-1:0] OP_CV_VARPOS    = 5'd13;
  localparam logic [OP_W-1:0] OP_CV_COV       = 5'd14;
  localparam logic [OP_W-1:0] OP_CV_VARVEL    = 5'd15;
  localparam logic [OP_W-1:0] OP_CV_HOLD      = 5'd16;
  localparam logic [OP_W-1:0] OP_DIV_START    = 5'd17;
  localparam logic [OP_W-1:0] OP_OUT_MUL_DTN  = 5'd18;
  localparam logic [OP_W-1:0] OP_OUT_DTN      = 5'd19;
  localparam logic [OP_W-1:0] OP_OUT_MUL_VDTN = 5'd20;
  localparam logic [OP_W-1:0] OP_OUT_AHEAD    = 5'd21;
  localparam logic [OP_W-1:0] OP_OUT_PUBLISH  = 5'd22;

  localparam logic signed [65:0] SAT_MAX = 66'sd2147483647;
  localparam logic signed [65:0] SAT_MIN = -SAT_MAX - 66'sd1;
  localparam logic signed [63:0] K_LIMIT = 64'sd17179869184;

  typedef struct packed {
    logic               opcode;
    logic signed [31:0] meas_x;
    logic signed [31:0] meas_y;
    logic signed [31:0] meas_z;
    logic [7:0]         lookahead_frames;
  } in_item_t;

  typedef struct packed {
    logic               tracking;
    logic signed [31:0] est_x;
    logic signed [31:0] est_y;
    logic signed [31:0] est_z;
    logic signed [31:0] ahead_x;
    logic signed [31:0] ahead_y;
    logic signed [31:0] ahead_z;
  } out_item_t;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [AXIS_W-1:0] axis;
    logic              load;
  } cmd_t;

  typedef struct packed {
    logic is_lost;
    logic track_valid;
    logic s_zero;
    logic div_done;
    logic out_free;
  } status_t;

  // Clamp to signed 32 bit
  function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
    logic signed [31:0] r;
    if (x > SAT_MAX) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < SAT_MIN) begin
      r = 32'sh8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  // Clamp a variance to [0, 2^31-1]
  function automatic logic signed [31:0] satvar(input logic signed [65:0] x);
    logic signed [31:0] r;
    if (x < 66'sd0) begin
      r = 32'sd0;
    end else begin
      r = sat32(x);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/constant_velocity_tracker_fixed_rate.sv -----
// Constant-velocity 3D tracker. One item at a time; in_ready is high only while idle.
// Lost frame or track start: decode, then the output steps (look-ahead per axis) and publish.
// Tracked measurement: prediction, per-axis update and covariance update on the bit-serial
// divider (nine quotients per update unless the innovation variance is zero), then output and publish.
// A result held by out_ready low stalls the controller before the next accept.
// Reset (rst, synchronous): configuration to defaults, track dropped, state cleared.
`default_nettype none

module constant_velocity_tracker_fixed_rate (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire cvt_pkg::in_item_t               in_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output cvt_pkg::out_item_t                   out_data,
  input  wire logic                            cfg_we,
  input  wire logic [cvt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [cvt_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import cvt_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequencer
  cvt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Arithmetic and state
  cvt_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

`default_nettype wire

// ----- rtl/cvt_div.sv -----
// Bit-serial signed divider: 64-bit dividend by 32-bit positive divisor, truncating.
// Depends on cvt_pkg.
`default_nettype none

module cvt_div (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [63:0] dividend,
  input  wire logic [31:0]        divisor,
  output logic                    done,
  output logic signed [63:0]      quotient
);
  import cvt_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 neg;
  logic [63:0]          mag;
  logic [31:0]          rem;
  logic [31:0]          dvs;
  logic [33:0]          trial;

  // Trial subtract of the shifted remainder
  assign trial = {1'b0, rem, mag[63]} - {2'b00, dvs};

  // Apply the sign after the magnitude is done
  assign quotient = neg ? $signed(64'd0 - mag) : $signed(mag);

  // Control: count steps, pulse done after the last one
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DIV_STEPS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: restoring division, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[63];
      mag <= dividend[63] ? (64'd0 - dividend) : dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      if (!trial[33]) begin
        rem <= trial[31:0];
        mag <= {mag[62:0], 1'b1};
      end else begin
        rem <= {rem[30:0], mag[63]};
        mag <= {mag[62:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/cvt_ctrl.sv -----
// Controller state machine that sequences the tracker datapath.
// Depends on cvt_pkg.
`default_nettype none

module cvt_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire cvt_pkg::status_t status,
  output cvt_pkg::cmd_t        cmd
);
  import cvt_pkg::*;

  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_DEC  = 5'd1;
  localparam logic [4:0] ST_P0   = 5'd2;
  localparam logic [4:0] ST_P1   = 5'd3;
  localparam logic [4:0] ST_P2   = 5'd4;
  localparam logic [4:0] ST_P3   = 5'd5;
  localparam logic [4:0] ST_X0   = 5'd6;
  localparam logic [4:0] ST_X1   = 5'd7;
  localparam logic [4:0] ST_X2   = 5'd8;
  localparam logic [4:0] ST_XD1  = 5'd9;
  localparam logic [4:0] ST_XW1  = 5'd10;
  localparam logic [4:0] ST_X4   = 5'd11;
  localparam logic [4:0] ST_XD2  = 5'd12;
  localparam logic [4:0] ST_XW2  = 5'd13;
  localparam logic [4:0] ST_X6   = 5'd14;
  localparam logic [4:0] ST_C0   = 5'd15;
  localparam logic [4:0] ST_CD1  = 5'd16;
  localparam logic [4:0] ST_CW1  = 5'd17;
  localparam logic [4:0] ST_C2   = 5'd18;
  localparam logic [4:0] ST_CD2  = 5'd19;
  localparam logic [4:0] ST_CW2  = 5'd20;
  localparam logic [4:0] ST_C4   = 5'd21;
  localparam logic [4:0] ST_CD3  = 5'd22;
  localparam logic [4:0] ST_CW3  = 5'd23;
  localparam logic [4:0] ST_C6   = 5'd24;
  localparam logic [4:0] ST_CZ   = 5'd25;
  localparam logic [4:0] ST_O0   = 5'd26;
  localparam logic [4:0] ST_O1   = 5'd27;
  localparam logic [4:0] ST_O2   = 5'd28;
  localparam logic [4:0] ST_O3   = 5'd29;
  localparam logic [4:0] ST_O4   = 5'd30;

  localparam logic [AXIS_W-1:0] LAST_AXIS = AXIS_W'(NUM_AXES - 1);

  logic [4:0]        state, state_next;
  logic [AXIS_W-1:0] axis, axis_next;

  assign in_ready = (state == ST_IDLE);

  // Next state and command decode
  always_comb begin
    state_next = state;
    axis_next  = axis;
    cmd.op     = OP_NOP;
    cmd.axis   = axis;
    cmd.load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_DEC;
        end
      end
      ST_DEC: begin
        priority if (status.is_lost) begin
          cmd.op     = OP_LOST;
          state_next = ST_O0;
        end else if (!status.track_valid) begin
          cmd.op     = OP_SEED;
          state_next = ST_O0;
        end else begin
          state_next = ST_P0;
        end
      end
      ST_P0: begin
        cmd.op     = OP_PRED_DTC;
        state_next = ST_P1;
      end
      ST_P1: begin
        cmd.op     = OP_PRED_DTB;
        state_next = ST_P2;
      end
      ST_P2: begin
        cmd.op     = OP_PRED_DTDTC;
        state_next = ST_P3;
      end
      ST_P3: begin
        cmd.op     = OP_PRED_COV;
        axis_next  = '0;
        state_next = ST_X0;
      end
      ST_X0: begin
        cmd.op     = OP_AX_MUL_VDT;
        state_next = ST_X1;
      end
      ST_X1: begin
        cmd.op = OP_AX_INNOV;
        if (status.s_zero) begin
          if (axis == LAST_AXIS) begin
            state_next = ST_CZ;
          end else begin
            axis_next  = axis + 1'b1;
            state_next = ST_X0;
          end
        end else begin
          state_next = ST_X2;
        end
      end
      ST_X2: begin
        cmd.op     = OP_AX_MUL_APE;
        state_next = ST_XD1;
      end
      ST_XD1: begin
        cmd.op     = OP_DIV_START;
        state_next = ST_XW1;
      end
      ST_XW1: begin
        if (status.div_done) state_next = ST_X4;
      end
      ST_X4: begin
        cmd.op     = OP_AX_POS;
        state_next = ST_XD2;
      end
      ST_XD2: begin
        cmd.op     = OP_DIV_START;
        state_next = ST_XW2;
      end
      ST_XW2: begin
        if (status.div_done) state_next = ST_X6;
      end
      ST_X6: begin
        cmd.op = OP_AX_VEL;
        if (axis == LAST_AXIS) begin
          state_next = ST_C0;
        end else begin
          axis_next  = axis + 1'b1;
          state_next = ST_X0;
        end
      end
      ST_C0: begin
        cmd.op     = OP_CV_MUL_APR;
        state_next = ST_CD1;
      end
      ST_CD1: begin
        cmd.op     = OP_DIV_START;
        state_next = ST_CW1;
      end
      ST_CW1: begin
        if (status.div_done) state_next = ST_C2;
      end
      ST_C2: begin
        cmd.op     = OP_CV_VARPOS;
        state_next = ST_CD2;
      end
      ST_CD2: begin
        cmd.op     = OP_DIV_START;
        state_next = ST_CW2;
      end
      ST_CW2: begin
        if (status.div_done) state_next = ST_C4;
      end
      ST_C4: begin
        cmd.op     = OP_CV_COV;
        state_next = ST_CD3;
      end
      ST_CD3: begin
        cmd.op     = OP_DIV_START;
        state_next = ST_CW3;
      end
      ST_CW3: begin
        if (status.div_done) state_next = ST_C6;
      end
      ST_C6: begin
        cmd.op     = OP_CV_VARVEL;
        state_next = ST_O0;
      end
      ST_CZ: begin
        cmd.op     = OP_CV_HOLD;
        state_next = ST_O0;
      end
      ST_O0: begin
        cmd.op     = OP_OUT_MUL_DTN;
        state_next = ST_O1;
      end
      ST_O1: begin
        cmd.op     = OP_OUT_DTN;
        axis_next  = '0;
        state_next = ST_O2;
      end
      ST_O2: begin
        cmd.op     = OP_OUT_MUL_VDTN;
        state_next = ST_O3;
      end
      ST_O3: begin
        cmd.op = OP_OUT_AHEAD;
        if (axis == LAST_AXIS) begin
          state_next = ST_O4;
        end else begin
          axis_next  = axis + 1'b1;
          state_next = ST_O2;
        end
      end
      ST_O4: begin
        // Hold until the output register is free
        if (status.out_free) begin
          cmd.op     = OP_OUT_PUBLISH;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      axis  <= '0;
    end else begin
      state <= state_next;
      axis  <= axis_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/cvt_datapath.sv -----
// Tracker datapath: configuration, filter state, shared multiplier, divider, result register.
// Depends on cvt_pkg and cvt_div.
`default_nettype none

module cvt_datapath (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire cvt_pkg::cmd_t                   cmd,
  output cvt_pkg::status_t                     status,
  input  wire cvt_pkg::in_item_t               in_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output cvt_pkg::out_item_t                   out_data,
  input  wire logic                            cfg_we,
  input  wire logic [cvt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [cvt_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import cvt_pkg::*;

  // Configuration registers
  logic [24:0] frame_period;
  logic [7:0]  max_lost;
  logic [30:0] process_noise;
  logic [30:0] measure_noise;
  logic [30:0] initial_variance;

  // Filter state
  logic               track_valid;
  logic [7:0]         lost_frames;
  logic signed [31:0] pos [NUM_AXES];
  logic signed [31:0] vel [NUM_AXES];
  logic signed [31:0] var_pos, cov_pos_vel, var_vel;

  // Latched item
  logic               item_lost;
  logic signed [31:0] meas [NUM_AXES];
  logic [7:0]         look_n;

  // Working registers
  logic signed [PROD_W-1:0] prod;
  logic signed [32:0]       dtc, t1, err;
  logic signed [31:0]       ap, bp, cp, xp;
  logic [32:0]              dtn;
  logic signed [31:0]       ahead [NUM_AXES];
  out_item_t                out_r;

  // Combinational terms
  logic signed [MUL_W-1:0] mul_a, mul_b;
  logic signed [PSH_W-1:0] psh;
  logic [31:0]             s_val;
  logic                    s_zero;
  logic signed [63:0]      quo;
  logic                    div_done;
  logic signed [31:0]      pos_sel, vel_sel, meas_sel;
  logic signed [31:0]      xp_sat;
  logic signed [32:0]      err_val;
  logic signed [63:0]      k_clamp;
  logic signed [65:0]      q66, r66, ap_sum;

  assign psh      = $signed(prod[PROD_W-1:COV_FRAC]);
  assign s_val    = $unsigned(ap) + {1'b0, measure_noise};
  assign s_zero   = (s_val == 32'd0);
  assign pos_sel  = pos[cmd.axis];
  assign vel_sel  = vel[cmd.axis];
  assign meas_sel = meas[cmd.axis];
  assign q66      = 66'($signed({1'b0, process_noise}));
  assign r66      = 66'($signed({1'b0, measure_noise}));

  // Predicted position and innovation for the current axis
  assign xp_sat  = sat32(66'(pos_sel) + 66'(psh));
  assign err_val = 33'(meas_sel) - 33'(xp_sat);

  // Predicted position variance: a + 2 dt b + dt (dt c) + q
  assign ap_sum = 66'(var_pos) + 66'(t1) + 66'(t1) + 66'(psh) + q66;

  // Velocity gain term clamped to +/- 2^34
  always_comb begin
    priority if (quo > K_LIMIT) begin
      k_clamp = K_LIMIT;
    end else if (quo < -K_LIMIT) begin
      k_clamp = -K_LIMIT;
    end else begin
      k_clamp = quo;
    end
  end

  // Select multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      OP_PRED_DTC: begin
        mul_a = MUL_W'($signed({1'b0, frame_period}));
        mul_b = MUL_W'(var_vel);
      end
      OP_PRED_DTB: begin
        mul_a = MUL_W'($signed({1'b0, frame_period}));
        mul_b = MUL_W'(cov_pos_vel);
      end
      OP_PRED_DTDTC: begin
        mul_a = MUL_W'($signed({1'b0, frame_period}));
        mul_b = MUL_W'(dtc);
      end
      OP_AX_MUL_VDT: begin
        mul_a = MUL_W'(vel_sel);
        mul_b = MUL_W'($signed({1'b0, frame_period}));
      end
      OP_AX_MUL_APE: begin
        mul_a = MUL_W'(ap);
        mul_b = MUL_W'(err);
      end
      OP_AX_POS: begin
        mul_a = MUL_W'(bp);
        mul_b = MUL_W'(err);
      end
      OP_CV_MUL_APR: begin
        mul_a = MUL_W'(ap);
        mul_b = MUL_W'($signed({1'b0, measure_noise}));
      end
      OP_CV_VARPOS: begin
        mul_a = MUL_W'(bp);
        mul_b = MUL_W'($signed({1'b0, measure_noise}));
      end
      OP_CV_COV: begin
        mul_a = MUL_W'(bp);
        mul_b = MUL_W'(bp);
      end
      OP_OUT_MUL_DTN: begin
        mul_a = MUL_W'($signed({1'b0, frame_period}));
        mul_b = MUL_W'($signed({1'b0, look_n}));
      end
      OP_OUT_MUL_VDTN: begin
        mul_a = MUL_W'(vel_sel);
        mul_b = MUL_W'($signed({1'b0, dtn}));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Shared multiplier, registered product
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  cvt_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.op == OP_DIV_START),
    .dividend (prod[63:0]),
    .divisor  (s_val),
    .done     (div_done),
    .quotient (quo)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_period     <= RST_FRAME_PERIOD;
      max_lost         <= RST_MAX_LOST;
      process_noise    <= RST_PROCESS_NOISE;
      measure_noise    <= RST_MEASURE_NOISE;
      initial_variance <= RST_INITIAL_VARIANCE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_PERIOD:     frame_period     <= cfg_data[24:0];
        REG_MAX_LOST:         max_lost         <= cfg_data[7:0];
        REG_PROCESS_NOISE:    process_noise    <= cfg_data;
        REG_MEASURE_NOISE:    measure_noise    <= cfg_data;
        REG_INITIAL_VARIANCE: initial_variance <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Latch the accepted item
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_lost <= in_data.opcode;
      meas[0]   <= in_data.meas_x;
      meas[1]   <= in_data.meas_y;
      meas[2]   <= in_data.meas_z;
      look_n    <= in_data.lookahead_frames;
    end
  end

  // Track control state
  always_ff @(posedge clk) begin
    if (rst) begin
      track_valid <= 1'b0;
      lost_frames <= '0;
    end else begin
      unique case (cmd.op)
        OP_SEED: begin
          track_valid <= 1'b1;
          lost_frames <= '0;
        end
        OP_PRED_DTC: begin
          lost_frames <= '0;
        end
        OP_LOST: begin
          if (lost_frames >= max_lost) track_valid <= 1'b0;
          if (lost_frames != LOST_MAX) lost_frames <= lost_frames + 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Estimate and covariance updates
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        pos[i] <= '0;
        vel[i] <= '0;
      end
      var_pos     <= $signed({1'b0, RST_INITIAL_VARIANCE});
      cov_pos_vel <= '0;
      var_vel     <= $signed({1'b0, RST_INITIAL_VARIANCE});
    end else begin
      unique case (cmd.op)
        OP_SEED: begin
          for (int i = 0; i < NUM_AXES; i++) begin
            pos[i] <= meas[i];
            vel[i] <= '0;
          end
          var_pos     <= $signed({1'b0, initial_variance});
          cov_pos_vel <= '0;
          var_vel     <= $signed({1'b0, initial_variance});
        end
        OP_AX_INNOV: begin
          // Zero innovation variance: keep the prediction
          if (s_zero) pos[cmd.axis] <= xp_sat;
        end
        OP_AX_POS: begin
          pos[cmd.axis] <= sat32(66'(xp) + 66'(quo));
        end
        OP_AX_VEL: begin
          vel[cmd.axis] <= sat32(66'(vel_sel) + 66'(k_clamp));
        end
        OP_CV_VARPOS: begin
          var_pos <= satvar(66'(quo));
        end
        OP_CV_COV: begin
          cov_pos_vel <= sat32(66'(quo));
        end
        OP_CV_VARVEL: begin
          var_vel <= satvar(66'(cp) - 66'(quo));
        end
        OP_CV_HOLD: begin
          var_pos     <= ap;
          cov_pos_vel <= bp;
          var_vel     <= cp;
        end
        default: begin
        end
      endcase
    end
  end

  // Working registers of the prediction, update and output steps
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_PRED_DTB: begin
        dtc <= psh[32:0];
      end
      OP_PRED_DTDTC: begin
        t1 <= psh[32:0];
      end
      OP_PRED_COV: begin
        ap <= satvar(ap_sum);
        bp <= sat32(66'(cov_pos_vel) + 66'(dtc));
        cp <= satvar(66'(var_vel) + q66);
      end
      OP_AX_INNOV: begin
        xp  <= xp_sat;
        err <= err_val;
      end
      OP_OUT_DTN: begin
        dtn <= prod[32:0];
      end
      OP_OUT_AHEAD: begin
        ahead[cmd.axis] <= track_valid ? sat32(66'(pos_sel) + 66'(psh)) : 32'sd0;
      end
      default: begin
      end
    endcase
  end

  // Result register: load on publish, drop when the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == OP_OUT_PUBLISH) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_OUT_PUBLISH) begin
      out_r.tracking <= track_valid;
      out_r.est_x    <= pos[0];
      out_r.est_y    <= pos[1];
      out_r.est_z    <= pos[2];
      out_r.ahead_x  <= ahead[0];
      out_r.ahead_y  <= ahead[1];
      out_r.ahead_z  <= ahead[2];
    end
  end

  assign out_data = out_r;

  assign status.is_lost     = item_lost;
  assign status.track_valid = track_valid;
  assign status.s_zero      = s_zero;
  assign status.div_done    = div_done;
  assign status.out_free    = !out_valid || out_ready;

endmodule

`default_nettype wire
